[src/sha256_leading_zero_pow_search_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the proof-of-work search block
// Shared helpers; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SHA256_LEADING_ZERO_POW_SEARCH_DEFINES_SVH
`define SHA256_LEADING_ZERO_POW_SEARCH_DEFINES_SVH

// same-cycle implication
`define SLZPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slzps: check failed");

// next-cycle implication
`define SLZPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slzps: check failed");

`endif

[src/slzps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slzps_pkg
// Types, constants and SHA-256 helpers for the proof-of-work search.
// ----------------------------------------------------------------------------
package slzps_pkg;

  localparam int unsigned Rounds = 64;
  localparam logic [8:0] DiffMax = 9'd256;
  localparam logic [8:0] DiffReset = 9'd16;
  localparam logic [31:0] LastCtr = 32'hFFFF_FFFE;
  localparam logic [31:0] MsgBits = 32'd64;
  localparam logic [31:0] PadWord = 32'h8000_0000;

  localparam logic [31:0] K_TAB [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // one candidate in flight through the rounds
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [31:0]      ctr;
    logic [0:7][31:0] hv;   // working variables a..h
    logic [0:15][31:0] w;   // schedule window, w[0] is this round's word
  } slzps_item_t;

  // candidate after digest check
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic        last;
    logic [31:0] ctr;
  } slzps_res_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[src/sha256_leading_zero_pow_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_leading_zero_pow_search
// SHA-256 proof-of-work search over counters for one nonce per transaction.
// ----------------------------------------------------------------------------
// One input transaction carries a 32-bit nonce. The block hashes the 8-byte
// message {nonce LE, counter LE} for counters 0, 1, 2 ... 0xFFFFFFFE and
// returns the first counter whose digest has at least 'difficulty' leading
// zero bits (difficulty above 256 acts as 256). out_tdata is the counter,
// out_tuser is the found flag; an exhausted search returns 0 with found low.
// Hashing runs in a 64-stage round pipeline plus two check stages: a fresh
// counter enters every cycle and its verdict comes out of the last check
// stage. The block takes one nonce at a time; a new nonce is accepted while
// the previous result still waits on the output.
// Difficulty is sampled when a nonce is accepted.
// ----------------------------------------------------------------------------
module sha256_leading_zero_pow_search (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] nonce
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] solution
  output logic        out_tuser,    // [0] found
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import slzps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t        state_r;
  logic [8:0]    diff_r;
  logic [31:0]   nonce_r;
  logic [31:0]   ctr_r;
  logic          issue_done_r;
  logic [255:0]  mask_r, mask_nxt;
  logic [8:0]    need;
  logic [31:0]   sol_r;
  logic          found_r;
  logic          out_tvalid_r;
  logic [31:0]   out_tdata_r;
  logic          out_tuser_r;

  logic          in_acc, issue, finish, flush, out_free;
  slzps_item_t   head;
  slzps_item_t   pipe [Rounds+1];
  slzps_res_t    res;

  // --- configuration port: register 0 is difficulty ---
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {23'd0, diff_r} : 32'd0;

  // --- search control ---
  assign in_acc   = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign issue    = (state_r == S_RUN) & ~issue_done_r & ~finish;
  assign finish   = (state_r == S_RUN) & res.vld & (res.hit | res.last);
  assign flush    = finish;                     // drop candidates past the winner
  assign out_free = ~out_tvalid_r | out_tready;

  assign need     = (diff_r > DiffMax) ? DiffMax : diff_r;
  assign mask_nxt = ~({256{1'b1}} >> need);

  // message block: nonce, counter, pad bit, zeros, bit length
  always_comb begin
    head.vld  = issue;
    head.last = (ctr_r == LastCtr);
    head.ctr  = ctr_r;
    head.hv   = IV;
    head.w    = '0;
    head.w[0] = bswap(nonce_r);
    head.w[1] = bswap(ctr_r);
    head.w[2] = PadWord;
    head.w[15] = MsgBits;
  end

  assign pipe[0] = head;

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    slzps_round #(.RoundIdx(g)) u_round (
      .clk  (clk),
      .rst_n(rst_n),
      .flush(flush),
      .d_in (pipe[g]),
      .d_out(pipe[g+1])
    );
  end

  slzps_check u_check (
    .clk  (clk),
    .rst_n(rst_n),
    .flush(flush),
    .mask (mask_r),
    .d_in (pipe[Rounds]),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      diff_r       <= DiffReset;
      issue_done_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == 1'b0) begin
        diff_r <= cfg_pwdata[8:0];
      end
      // in S_HOLD the output register is reloaded below instead
      if (out_tvalid_r && out_tready && state_r != S_HOLD) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            nonce_r      <= in_tdata;
            ctr_r        <= 32'd0;
            issue_done_r <= 1'b0;
            mask_r       <= mask_nxt;
            state_r      <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            ctr_r <= ctr_r + 32'd1;
            if (ctr_r == LastCtr) begin
              issue_done_r <= 1'b1;
            end
          end
          if (finish) begin
            sol_r   <= res.hit ? res.ctr : 32'd0;
            found_r <= res.hit;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= sol_r;
            out_tuser_r  <= found_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[src/slzps_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slzps_round
// One registered SHA-256 round plus one schedule word.
// ----------------------------------------------------------------------------
module slzps_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 flush,
  input  slzps_pkg::slzps_item_t d_in,
  output slzps_pkg::slzps_item_t d_out
);
  import slzps_pkg::*;

  slzps_item_t q_r, q_nxt;
  logic [31:0] t1, t2, s0, s1, w_new;

  always_comb begin
    t1 = d_in.hv[7] + (rotr(d_in.hv[4], 6) ^ rotr(d_in.hv[4], 11) ^ rotr(d_in.hv[4], 25))
       + ((d_in.hv[4] & d_in.hv[5]) ^ (~d_in.hv[4] & d_in.hv[6]))
       + K_TAB[RoundIdx] + d_in.w[0];
    t2 = (rotr(d_in.hv[0], 2) ^ rotr(d_in.hv[0], 13) ^ rotr(d_in.hv[0], 22))
       + ((d_in.hv[0] & d_in.hv[1]) ^ (d_in.hv[0] & d_in.hv[2]) ^ (d_in.hv[1] & d_in.hv[2]));
    s0 = rotr(d_in.w[1], 7) ^ rotr(d_in.w[1], 18) ^ (d_in.w[1] >> 3);
    s1 = rotr(d_in.w[14], 17) ^ rotr(d_in.w[14], 19) ^ (d_in.w[14] >> 10);
    w_new = d_in.w[0] + s0 + d_in.w[9] + s1;

    q_nxt      = d_in;
    // reset and flush both clear the valid bit
    q_nxt.vld  = rst_n & d_in.vld & ~flush;
    q_nxt.hv   = {t1 + t2, d_in.hv[0], d_in.hv[1], d_in.hv[2],
                  d_in.hv[3] + t1, d_in.hv[4], d_in.hv[5], d_in.hv[6]};
    q_nxt.w    = {d_in.w[1:15], w_new};
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign d_out = q_r;

endmodule

[src/slzps_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slzps_check
// Final digest add, then leading-zero test against the difficulty mask.
// ----------------------------------------------------------------------------
module slzps_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  flush,
  input  logic [255:0]          mask,
  input  slzps_pkg::slzps_item_t d_in,
  output slzps_pkg::slzps_res_t  res
);
  import slzps_pkg::*;

  logic             vld_r, last_r;
  logic [31:0]      ctr_r;
  logic [0:7][31:0] dig_r, dig_nxt;
  slzps_res_t       res_r, res_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dig_nxt[i] = IV[i] + d_in.hv[i];
    end
    // reset and flush both clear the valid bit
    res_nxt.vld  = rst_n & vld_r & ~flush;
    res_nxt.hit  = ((dig_r & mask) == '0);
    res_nxt.last = last_r;
    res_nxt.ctr  = ctr_r;
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    ctr_r  <= d_in.ctr;
    last_r <= d_in.last;
    res_r  <= res_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d_in.vld & ~flush;
    end
  end

  assign res = res_r;

endmodule

[src/slzps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slzps_checker
// Port-level checks for the proof-of-work search, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_leading_zero_pow_search_defines.svh"

module slzps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // stalled result holds
  `SLZPS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a failed search reports counter zero
  `SLZPS_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser, out_tdata == 32'd0)
  // one search at a time: busy right after a nonce is taken
  `SLZPS_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
  // no result can appear in the cycle after a nonce is taken unless one was pending
  `SLZPS_ASSERT_NXT(a_no_instant, in_tvalid && in_tready && !out_tvalid, !out_tvalid)

endmodule

bind sha256_leading_zero_pow_search slzps_checker u_slzps_checker (.*);
